// ===== design/isc_pkg.sv =====
// Shared types, edge codes and helpers for the isoline cell segment block.
`timescale 1ns / 1ps
package isc_pkg;

  localparam logic [2:0] EDGE_TOP    = 3'd0;
  localparam logic [2:0] EDGE_RIGHT  = 3'd1;
  localparam logic [2:0] EDGE_BOTTOM = 3'd2;
  localparam logic [2:0] EDGE_LEFT   = 3'd3;
  localparam logic [2:0] EDGE_DIAG   = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  // Crossing plan for one cell: up to four crossing slots, up to two segments.
  typedef struct packed {
    logic [3:0][1:0] pu;
    logic [3:0][1:0] pv;
    logic [3:0]      need;
    logic            two_seg;
    logic [1:0]      sa0;
    logic [1:0]      sb0;
    logic [1:0]      sa1;
    logic [1:0]      sb1;
    logic [2:0]      ea0;
    logic [2:0]      eb0;
    logic [2:0]      ea1;
    logic [2:0]      eb1;
  } plan_t;

  // Edge code of the triangle side from corner u to corner v.
  function automatic logic [2:0] edge_code(input logic [1:0] u, input logic [1:0] v);
    logic [1:0] dif;
    logic [2:0] code;
    dif = u - v;
    if (dif == 2'd2) begin
      code = EDGE_DIAG + {1'b0, u};
    end else if ((u == 2'd0 && v == 2'd1) || (u == 2'd1 && v == 2'd0)) begin
      code = EDGE_TOP;
    end else if ((u == 2'd1 && v == 2'd2) || (u == 2'd2 && v == 2'd1)) begin
      code = EDGE_RIGHT;
    end else if ((u == 2'd2 && v == 2'd3) || (u == 2'd3 && v == 2'd2)) begin
      code = EDGE_BOTTOM;
    end else begin
      code = EDGE_LEFT;
    end
    return code;
  endfunction

endpackage

// ===== design/isc_queue.sv =====
// Short queue of cell descriptors between the classifier and the segment engine.
`timescale 1ns / 1ps
module isc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PW = (isc_pkg::QUEUE_DEPTH > 1) ? $clog2(isc_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(isc_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [isc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CW'(isc_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PW'(isc_pkg::QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == PW'(isc_pkg::QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== design/isc_front.sv =====
// Classifier: holds the level, accepts cells and plans their crossings and segments.
`timescale 1ns / 1ps
module isc_front #(
  parameter int W      = 32,
  parameter int IW     = 12,
  parameter int DESC_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [W-1:0]      cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [8*W+2*IW-1:0] in_data,
  input  logic [3:0]        in_mask,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [DESC_W-1:0] q_data
);
  logic [W-1:0]        level;
  logic [3:0][W-1:0]   z;
  logic [3:0]          up;
  logic [3:0]          has;
  logic                high;
  logic signed [W+1:0] sum;
  logic signed [W+1:0] lv4;
  logic                any_seg;
  isc_pkg::plan_t      plan;
  logic [1:0]          missing;
  logic [2:0][1:0]     ord;
  logic [2:0]          xs;
  logic [1:0]          s0;
  logic [1:0]          s1;
  logic [1:0]          u0, v0, u1, v1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cfg_valid) begin
      level <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      z[k]  = in_data[k*W +: W];
      up[k] = $signed(z[k]) > $signed(level);
    end
    has[0] = up[0] ^ up[1];
    has[1] = up[1] ^ up[2];
    has[2] = up[3] ^ up[2];
    has[3] = up[0] ^ up[3];
    sum = $signed({{2{z[0][W-1]}}, z[0]}) + $signed({{2{z[1][W-1]}}, z[1]})
        + $signed({{2{z[2][W-1]}}, z[2]}) + $signed({{2{z[3][W-1]}}, z[3]});
    lv4  = $signed({level, 2'b00});
    high = sum > lv4;

    missing = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (!in_mask[k]) begin
        missing = 2'(k);
      end
    end
    case (missing)
      2'd0:    ord = {2'd3, 2'd2, 2'd1};
      2'd1:    ord = {2'd3, 2'd2, 2'd0};
      2'd2:    ord = {2'd3, 2'd1, 2'd0};
      default: ord = {2'd2, 2'd1, 2'd0};
    endcase
    xs[0] = up[ord[0]] ^ up[ord[1]];
    xs[1] = up[ord[1]] ^ up[ord[2]];
    xs[2] = up[ord[2]] ^ up[ord[0]];
    if (xs[0] && xs[1]) begin
      s0 = 2'd0;
      s1 = 2'd1;
    end else if (xs[0] && xs[2]) begin
      s0 = 2'd0;
      s1 = 2'd2;
    end else begin
      s0 = 2'd1;
      s1 = 2'd2;
    end
    u0 = ord[s0];
    v0 = (s0 == 2'd2) ? ord[0] : ord[s0 + 2'd1];
    u1 = ord[s1];
    v1 = (s1 == 2'd2) ? ord[0] : ord[s1 + 2'd1];

    plan    = '0;
    any_seg = 1'b0;
    if (in_mask == 4'hF) begin
      // Quad slots follow the edge codes: top, right, bottom, left.
      plan.pu = {2'd0, 2'd3, 2'd1, 2'd0};
      plan.pv = {2'd3, 2'd2, 2'd2, 2'd1};
      if (has == 4'hF) begin
        any_seg      = 1'b1;
        plan.need    = 4'hF;
        plan.two_seg = 1'b1;
        if (up[0] != high) begin
          plan.sa0 = 2'd0; plan.sb0 = 2'd3; plan.sa1 = 2'd1; plan.sb1 = 2'd2;
        end else begin
          plan.sa0 = 2'd0; plan.sb0 = 2'd1; plan.sa1 = 2'd2; plan.sb1 = 2'd3;
        end
      end else if (has != 4'h0) begin
        any_seg = 1'b1;
        if (has[0] && has[1]) begin
          plan.sa0 = 2'd0; plan.sb0 = 2'd1;
        end else if (has[1] && has[2]) begin
          plan.sa0 = 2'd1; plan.sb0 = 2'd2;
        end else if (has[2] && has[3]) begin
          plan.sa0 = 2'd2; plan.sb0 = 2'd3;
        end else if (has[3] && has[0]) begin
          plan.sa0 = 2'd3; plan.sb0 = 2'd0;
        end else if (has[0] && has[2]) begin
          plan.sa0 = 2'd0; plan.sb0 = 2'd2;
        end else begin
          plan.sa0 = 2'd3; plan.sb0 = 2'd1;
        end
        plan.need[plan.sa0] = 1'b1;
        plan.need[plan.sb0] = 1'b1;
      end
      plan.ea0 = {1'b0, plan.sa0};
      plan.eb0 = {1'b0, plan.sb0};
      plan.ea1 = {1'b0, plan.sa1};
      plan.eb1 = {1'b0, plan.sb1};
    end else if ($countones(in_mask) == 3) begin
      // Triangle: a side crossing count is zero or two.
      any_seg   = (xs != 3'b000);
      plan.pu[0] = u0;
      plan.pv[0] = v0;
      plan.pu[1] = u1;
      plan.pv[1] = v1;
      plan.need  = 4'b0011;
      plan.sa0   = 2'd0;
      plan.sb0   = 2'd1;
      plan.ea0   = isc_pkg::edge_code(u0, v0);
      plan.eb0   = isc_pkg::edge_code(u1, v1);
    end
  end

  // Cells with no segment are dropped here.
  assign in_ready = q_ready;
  assign q_valid  = in_valid && any_seg;
  assign q_data   = {in_data, level, plan};
endmodule

// ===== design/isc_interp.sv =====
// Serial multiply-divide unit: cu + trunc(num * d / den), one quotient digit a cycle.
`timescale 1ns / 1ps
module isc_interp #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] cu,
  input  logic [W:0]   num,
  input  logic [W:0]   den,
  input  logic [W:0]   d,
  output logic         done,
  output logic [W-1:0] res
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W-1:0]  dn;
  logic [W-1:0]  r;
  logic [W-1:0]  q;
  logic [W-1:0]  base;
  logic          neg;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [W:0]    abs_num, abs_den, abs_d;
  logic [W+1:0]  r2, dn1, dn2;
  logic [W-1:0]  r_next;
  logic [1:0]    dgt;

  assign abs_num = num[W] ? (~num + 1'b1) : num;
  assign abs_den = den[W] ? (~den + 1'b1) : den;
  assign abs_d   = d[W] ? (~d + 1'b1) : d;

  // Remainder stays below den, so 2r + a stays below three times den.
  always_comb begin
    r2  = {r, 1'b0} + (b[W-1] ? {2'b00, a} : '0);
    dn1 = {2'b00, dn};
    dn2 = {1'b0, dn, 1'b0};
    if (r2 >= dn2) begin
      r_next = W'(r2 - dn2);
      dgt    = 2'd2;
    end else if (r2 >= dn1) begin
      r_next = W'(r2 - dn1);
      dgt    = 2'd1;
    end else begin
      r_next = W'(r2);
      dgt    = 2'd0;
    end
  end

  assign res = neg ? (base - q) : (base + q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= abs_num[W-1:0];
      b    <= abs_d[W-1:0];
      dn   <= abs_den[W-1:0];
      r    <= '0;
      q    <= '0;
      base <= cu;
      neg  <= num[W] ^ den[W] ^ d[W];
    end else if (busy) begin
      r <= r_next;
      q <= W'({q, 1'b0} + {{(W-1){1'b0}}, dgt});
      b <= {b[W-2:0], 1'b0};
    end
  end
endmodule

// ===== design/isc_back.sv =====
// Segment engine: interpolates the planned crossings and emits the segments.
`timescale 1ns / 1ps
module isc_back #(
  parameter int W      = 32,
  parameter int IW     = 12,
  parameter int DESC_W = 8,
  parameter int OUT_W  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [DESC_W-1:0] q_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast
);
  localparam int PW = $bits(isc_pkg::plan_t);

  typedef enum logic [2:0] {
    B_IDLE, B_PICK, B_LOAD, B_RUN, B_EMIT
  } state_t;

  state_t             state;
  isc_pkg::plan_t     plan;
  logic [W-1:0]       level;
  logic [3:0][W-1:0]  z;
  logic [W-1:0]       xl, xr, yt, yb;
  logic [IW-1:0]      row, col;
  logic [1:0]         slot;
  logic               seg_i;
  logic [3:0][W-1:0]  px, py;
  logic [W:0]         num, den, dx, dy;
  logic [W-1:0]       cux, cuy;
  logic [1:0]         u, v;
  logic [W-1:0]       zu, zv, cxu, cxv, cyu, cyv;
  logic               x_done, y_done;
  logic [W-1:0]       x_res, y_res;
  logic [1:0]         sa, sb;
  logic [2:0]         ea, eb;
  logic               seg_last;

  assign q_ready = (state == B_IDLE);

  always_comb begin
    u   = plan.pu[slot];
    v   = plan.pv[slot];
    zu  = z[u];
    zv  = z[v];
    cxu = (u == 2'd0 || u == 2'd3) ? xl : xr;
    cxv = (v == 2'd0 || v == 2'd3) ? xl : xr;
    cyu = (u[1] == 1'b0) ? yt : yb;
    cyv = (v[1] == 1'b0) ? yt : yb;
    sa  = seg_i ? plan.sa1 : plan.sa0;
    sb  = seg_i ? plan.sb1 : plan.sb0;
    ea  = seg_i ? plan.ea1 : plan.ea0;
    eb  = seg_i ? plan.eb1 : plan.eb0;
    seg_last = plan.two_seg ? seg_i : 1'b1;
  end

  isc_interp #(.W(W)) u_ix (
    .clk(clk), .rst(rst), .start(state == B_LOAD), .cu(cux),
    .num(num), .den(den), .d(dx), .done(x_done), .res(x_res)
  );

  isc_interp #(.W(W)) u_iy (
    .clk(clk), .rst(rst), .start(state == B_LOAD), .cu(cuy),
    .num(num), .den(den), .d(dy), .done(y_done), .res(y_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
      slot     <= '0;
      seg_i    <= 1'b0;
    end else begin
      // Hold the item while the receiver stalls.
      m_tvalid <= (state == B_EMIT) || (m_tvalid && !m_tready);
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            slot  <= '0;
            seg_i <= 1'b0;
            state <= B_PICK;
          end
        end
        B_PICK: begin
          if (plan.need[slot]) begin
            state <= B_LOAD;
          end else if (slot == 2'd3) begin
            state <= B_EMIT;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        B_LOAD: begin
          state <= B_RUN;
        end
        B_RUN: begin
          if (x_done && y_done) begin
            if (slot == 2'd3) begin
              state <= B_EMIT;
            end else begin
              slot  <= slot + 1'b1;
              state <= B_PICK;
            end
          end
        end
        B_EMIT: begin
          if (!m_tvalid || m_tready) begin
            if (seg_last) begin
              state <= B_IDLE;
            end else begin
              seg_i <= 1'b1;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid) begin
      plan  <= q_data[PW-1:0];
      level <= q_data[PW +: W];
      for (int k = 0; k < 4; k++) begin
        z[k] <= q_data[PW + (k+1)*W +: W];
      end
      xl  <= q_data[PW + 5*W +: W];
      xr  <= q_data[PW + 6*W +: W];
      yt  <= q_data[PW + 7*W +: W];
      yb  <= q_data[PW + 8*W +: W];
      row <= q_data[PW + 9*W +: IW];
      col <= q_data[PW + 9*W + IW +: IW];
    end
    if (state == B_PICK) begin
      num <= {level[W-1], level} - {zu[W-1], zu};
      den <= {zv[W-1], zv} - {zu[W-1], zu};
      dx  <= {cxv[W-1], cxv} - {cxu[W-1], cxu};
      dy  <= {cyv[W-1], cyv} - {cyu[W-1], cyu};
      cux <= cxu;
      cuy <= cyu;
    end
    if (state == B_RUN && x_done) begin
      px[slot] <= x_res;
      py[slot] <= y_res;
    end
    if (state == B_EMIT && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_W'({col, row, eb, ea, py[sb], px[sb], py[sa], px[sa]});
      m_tlast <= seg_last;
    end
  end
endmodule

// ===== design/isoline_cell_segments.sv =====
// Top level of the isoline cell segment block: classifier, queue and segment engine.
//
// Channel  Dir  Handshake            Contents
// s_*      in   s_tvalid/s_tready    one grid cell (tdata) and corner valid mask (tuser)
// m_*      out  m_tvalid/m_tready    one segment (tdata), last segment of cell (tlast)
// cfg_*    in   cfg_valid/cfg_ready  contour level
//
// The classifier takes a cell every cycle while the two-entry queue has room.
// The engine takes a cell, visits each of the four plan slots in turn, runs each needed
// crossing through two serial multiply-divide units (one quotient digit a cycle, for x
// and y) and then emits each segment; a saddle gives two segments. rst clears control
// state and the contour level only; a stalled m_tready holds the output register and
// the engine, while the queue takes cells until it is full.
`timescale 1ns / 1ps
module isoline_cell_segments #(
  parameter int INDEX_WIDTH = 12,
  parameter int DATA_WIDTH  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [DATA_WIDTH-1:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  // z_top_left, z_top_right, z_bottom_right, z_bottom_left, x_left, x_right,
  // y_top, y_bottom, cell_row, cell_col, zero fill
  input  logic [((8*DATA_WIDTH+2*INDEX_WIDTH+7)/8)*8-1:0] s_tdata,
  // valid_mask
  input  logic [3:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // start_x, start_y, end_x, end_y, start_edge, end_edge, out_row, out_col, zero fill
  output logic [((4*DATA_WIDTH+6+2*INDEX_WIDTH+7)/8)*8-1:0] m_tdata,
  output logic m_tlast
);
  localparam int IN_BITS = 8*DATA_WIDTH + 2*INDEX_WIDTH;
  localparam int OUT_W   = ((4*DATA_WIDTH + 6 + 2*INDEX_WIDTH + 7) / 8) * 8;
  localparam int DESC_W  = $bits(isc_pkg::plan_t) + 9*DATA_WIDTH + 2*INDEX_WIDTH;

  logic              fq_valid, fq_ready, bq_valid, bq_ready;
  logic [DESC_W-1:0] fq_data, bq_data;

  isc_front #(.W(DATA_WIDTH), .IW(INDEX_WIDTH), .DESC_W(DESC_W)) u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata[IN_BITS-1:0]),
    .in_mask(s_tuser),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  isc_queue #(.WIDTH(DESC_W)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  isc_back #(.W(DATA_WIDTH), .IW(INDEX_WIDTH), .DESC_W(DESC_W), .OUT_W(OUT_W)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );
endmodule
